[rtl/grcc_pkg.sv]
// grcc_pkg: shared types and constants of the grid ray caster column core
// depends on nothing; used by the core and its checker
package grcc_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_YWB,
        ST_STEP,
        ST_CHECK,
        ST_DIV_DIST,
        ST_DIV_HT,
        ST_TEX_MUL,
        ST_TEX_FRAC,
        ST_TEX_WB,
        ST_DONE
    } state_t;

    localparam logic CMD_MAP_WRITE = 1'b0;
    localparam logic CMD_CAST      = 1'b1;

    localparam logic REG_SCREEN_HEIGHT = 1'b0;
    localparam logic REG_TEXTURE_WIDTH = 1'b1;

    localparam logic [12:0] SCREEN_HEIGHT_RESET = 13'd480;
    localparam logic [10:0] TEXTURE_WIDTH_RESET = 11'd64;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

endpackage

[rtl/grid_ray_caster_column_core.sv]
// grid_ray_caster_column_core: dda ray walk over a one-bit wall map, perpendicular
// distance, slice height and texture column; depends on grcc_pkg
//
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    cmd, cell_row, cell_col, cell_is_wall,
//                                          pos_*, ray_*, delta_*
// out      output     out_valid/out_stall  hit_found, hit_side, hit_cell_*,
//                                          wall_distance, slice_*, texture_column
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a cast runs the side-distance products, then a step and a map read per walk step;
// on a hit the shared divider, one quotient bit a cycle, gives the distance and then
// the height (NW bits each, NW = 34 + signed cell index width, 42 at the default sizes),
// followed by the texture products; a miss skips the divisions and the texture steps
// after reset the map is cleared one cell a cycle and in_stall stays high meanwhile;
// configuration transfers are taken at any time
// a finished result waits in the output register while the next item is taken
module grid_ray_caster_column_core #(
    parameter int MAP_WIDTH      = 64,
    parameter int MAP_HEIGHT     = 64,
    parameter int MAX_WALK_STEPS = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [5:0]         cell_row,
    input  logic [5:0]         cell_col,
    input  logic               cell_is_wall,
    input  logic [21:0]        pos_x,
    input  logic [21:0]        pos_y,
    input  logic signed [18:0] ray_x,
    input  logic signed [18:0] ray_y,
    input  logic [31:0]        delta_x,
    input  logic [31:0]        delta_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit_found,
    output logic               hit_side,
    output logic [5:0]         hit_cell_x,
    output logic [5:0]         hit_cell_y,
    output logic [31:0]        wall_distance,
    output logic [15:0]        slice_height,
    output logic [12:0]        slice_begin,
    output logic [12:0]        slice_end,
    output logic [9:0]         texture_column,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [12:0]        cfg_data
);

    localparam int DEPTH  = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int MAXDIM = (MAP_WIDTH > MAP_HEIGHT) ?
                            ((MAP_WIDTH > 64) ? MAP_WIDTH : 64) :
                            ((MAP_HEIGHT > 64) ? MAP_HEIGHT : 64);
    localparam int GW     = $clog2(MAXDIM + 1) + 1;
    localparam int NCW    = $clog2(MAX_WALK_STEPS + 1);
    localparam int SW     = 33 + NCW;
    localparam int NUMW   = GW + 18;
    localparam int NW     = NUMW + 16;
    localparam int DCW    = $clog2(NW);
    localparam int LW     = AW + GW;

    grcc_pkg::state_t state_reg, state_next;

    logic [12:0] sh_reg;
    logic [10:0] tw_reg;

    logic [AW-1:0] clr_cnt_reg;
    logic          mem [DEPTH];
    logic          rd_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] rd_addr;
    logic [LW-1:0] rd_lin;
    logic [AW+5:0] wr_lin;

    logic [21:0]        px_reg, py_reg;
    logic signed [18:0] rx_reg, ry_reg;
    logic [31:0]        dx_reg, dy_reg;

    logic signed [GW-1:0] gx_reg, gy_reg, gx_next, gy_next;
    logic [SW-1:0]        nx_reg, ny_reg;
    logic [NCW-1:0]       n_reg;
    logic                 side_reg, hit_reg, step_x;

    logic [31:0]        mul_a;
    logic signed [19:0] mul_b;
    logic signed [52:0] mul_p_reg;
    logic [16:0]        part_x, part_y;

    logic [NW-1:0]  quo_reg, quo_nx;
    logic [31:0]    rem_reg, rem_nx, div_reg;
    logic [32:0]    trial;
    logic [DCW-1:0] dcnt_reg;
    logic           div_last;

    logic signed [NUMW-1:0] num;
    logic [NUMW-1:0]        an;
    logic [18:0]            ar;
    logic [31:0]            dist_sat;
    logic [15:0]            ht_sat;

    logic [31:0] dist_reg;
    logic [15:0] height_reg;
    logic [12:0] beg_reg, end_reg;
    logic [9:0]  tex_reg;
    logic [15:0] frac;
    logic [11:0] half;
    logic [14:0] h2;
    logic [15:0] end_sum;
    logic [10:0] tex_raw;
    logic        mirror;
    logic        map_out;

    logic in_take, out_free;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != grcc_pkg::ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid || !out_stall;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg <= grcc_pkg::SCREEN_HEIGHT_RESET;
            tw_reg <= grcc_pkg::TEXTURE_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                grcc_pkg::REG_SCREEN_HEIGHT: sh_reg <= cfg_data;
                grcc_pkg::REG_TEXTURE_WIDTH: tw_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // walk step and map addressing
    assign step_x  = nx_reg < ny_reg;
    assign gx_next = step_x ? (rx_reg < 0 ? gx_reg - GW'(1) : gx_reg + GW'(1)) : gx_reg;
    assign gy_next = step_x ? gy_reg : (ry_reg < 0 ? gy_reg - GW'(1) : gy_reg + GW'(1));
    assign rd_lin  = LW'($unsigned(gx_next)) * LW'(MAP_HEIGHT) + LW'($unsigned(gy_next));
    assign rd_addr = rd_lin[AW-1:0];
    assign wr_lin  = (AW+6)'(cell_row) * (AW+6)'(MAP_HEIGHT) + (AW+6)'(cell_col);
    assign map_out = (gx_reg < 0) || (gx_reg >= GW'(MAP_WIDTH)) ||
                     (gy_reg < 0) || (gy_reg >= GW'(MAP_HEIGHT));

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = 1'b0;
        if (state_reg == grcc_pkg::ST_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (in_take && cmd == grcc_pkg::CMD_MAP_WRITE &&
                 32'(cell_row) < 32'(MAP_WIDTH) && 32'(cell_col) < 32'(MAP_HEIGHT))
        begin
            mem_we    = 1'b1;
            mem_waddr = wr_lin[AW-1:0];
            mem_wdata = cell_is_wall;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[rd_addr];
    end

    // shared multiplier
    assign part_x = (rx_reg < 0) ? {1'b0, px_reg[15:0]} :
                                   grcc_pkg::ONE_Q16 - {1'b0, px_reg[15:0]};
    assign part_y = (ry_reg < 0) ? {1'b0, py_reg[15:0]} :
                                   grcc_pkg::ONE_Q16 - {1'b0, py_reg[15:0]};
    assign frac   = (side_reg ? px_reg[15:0] : py_reg[15:0]) + mul_p_reg[31:16];

    always_comb
    begin
        mul_a = dx_reg;
        mul_b = signed'({3'b000, part_x});
        unique case (state_reg)
            grcc_pkg::ST_MUL_Y:
            begin
                mul_a = dy_reg;
                mul_b = signed'({3'b000, part_y});
            end
            grcc_pkg::ST_TEX_MUL:
            begin
                mul_a = dist_reg;
                mul_b = side_reg ? 20'(rx_reg) : 20'(ry_reg);
            end
            grcc_pkg::ST_TEX_FRAC:
            begin
                mul_a = {16'h0000, frac};
                mul_b = signed'({9'h000, tw_reg});
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= $signed({1'b0, mul_a}) * mul_b;
    end

    // shared restoring divider, one quotient bit a cycle
    assign trial    = {rem_reg, quo_reg[NW-1]};
    assign rem_nx   = (trial >= {1'b0, div_reg}) ? 32'(trial - {1'b0, div_reg}) : trial[31:0];
    assign quo_nx   = {quo_reg[NW-2:0], trial >= {1'b0, div_reg}};
    assign div_last = dcnt_reg == DCW'(NW - 1);
    assign dist_sat = (|quo_nx[NW-1:32]) ? 32'hFFFF_FFFF : quo_nx[31:0];
    assign ht_sat   = (|quo_nx[NW-1:16]) ? 16'hFFFF : quo_nx[15:0];

    always_comb
    begin
        if (side_reg)
        begin
            num = (NUMW'(gy_reg) <<< 16) + (ry_reg < 0 ? NUMW'(65536) : NUMW'(0))
                  - NUMW'(py_reg);
            ar  = (ry_reg < 0) ? 19'(-ry_reg) : 19'(ry_reg);
        end
        else
        begin
            num = (NUMW'(gx_reg) <<< 16) + (rx_reg < 0 ? NUMW'(65536) : NUMW'(0))
                  - NUMW'(px_reg);
            ar  = (rx_reg < 0) ? 19'(-rx_reg) : 19'(rx_reg);
        end
        an = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    end

    // slice rows and texture column
    assign half    = sh_reg[12:1];
    assign h2      = height_reg[15:1];
    assign end_sum = 16'(half) + 16'(h2);
    assign tex_raw = mul_p_reg[26:16];
    assign mirror  = side_reg ? (ry_reg < 0) : (rx_reg > 0);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grcc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            grcc_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = grcc_pkg::ST_IDLE;
                end
            end
            grcc_pkg::ST_IDLE:
            begin
                if (in_take && cmd == grcc_pkg::CMD_CAST)
                begin
                    state_next = grcc_pkg::ST_MUL_X;
                end
            end
            grcc_pkg::ST_MUL_X:   state_next = grcc_pkg::ST_MUL_Y;
            grcc_pkg::ST_MUL_Y:   state_next = grcc_pkg::ST_MUL_YWB;
            grcc_pkg::ST_MUL_YWB: state_next = grcc_pkg::ST_STEP;
            grcc_pkg::ST_STEP:
            begin
                if (n_reg == NCW'(MAX_WALK_STEPS))
                begin
                    state_next = grcc_pkg::ST_DONE;
                end
                else
                begin
                    state_next = grcc_pkg::ST_CHECK;
                end
            end
            grcc_pkg::ST_CHECK:
            begin
                priority if (map_out)
                begin
                    state_next = grcc_pkg::ST_DONE;
                end
                else if (rd_reg)
                begin
                    state_next = grcc_pkg::ST_DIV_DIST;
                end
                else
                begin
                    state_next = grcc_pkg::ST_STEP;
                end
            end
            grcc_pkg::ST_DIV_DIST:
            begin
                if (div_last)
                begin
                    state_next = grcc_pkg::ST_DIV_HT;
                end
            end
            grcc_pkg::ST_DIV_HT:
            begin
                if (div_last)
                begin
                    state_next = grcc_pkg::ST_TEX_MUL;
                end
            end
            grcc_pkg::ST_TEX_MUL:  state_next = grcc_pkg::ST_TEX_FRAC;
            grcc_pkg::ST_TEX_FRAC: state_next = grcc_pkg::ST_TEX_WB;
            grcc_pkg::ST_TEX_WB:   state_next = grcc_pkg::ST_DONE;
            grcc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = grcc_pkg::ST_IDLE;
                end
            end
            default: state_next = grcc_pkg::ST_IDLE;
        endcase
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (state_reg == grcc_pkg::ST_CLEAR)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            grcc_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    px_reg <= pos_x;
                    py_reg <= pos_y;
                    rx_reg <= ray_x;
                    ry_reg <= ray_y;
                    dx_reg <= delta_x;
                    dy_reg <= delta_y;
                    gx_reg <= GW'($signed({1'b0, pos_x[21:16]}));
                    gy_reg <= GW'($signed({1'b0, pos_y[21:16]}));
                    side_reg <= 1'b0;
                    hit_reg  <= 1'b0;
                end
            end
            grcc_pkg::ST_MUL_Y:
            begin
                nx_reg <= SW'(mul_p_reg[48:16]);
            end
            grcc_pkg::ST_MUL_YWB:
            begin
                ny_reg <= SW'(mul_p_reg[48:16]);
                n_reg  <= '0;
            end
            grcc_pkg::ST_STEP:
            begin
                if (n_reg != NCW'(MAX_WALK_STEPS))
                begin
                    n_reg    <= n_reg + NCW'(1);
                    gx_reg   <= gx_next;
                    gy_reg   <= gy_next;
                    side_reg <= !step_x;
                    if (step_x)
                    begin
                        nx_reg <= nx_reg + SW'(dx_reg);
                    end
                    else
                    begin
                        ny_reg <= ny_reg + SW'(dy_reg);
                    end
                end
            end
            grcc_pkg::ST_CHECK:
            begin
                if (!map_out && rd_reg)
                begin
                    hit_reg  <= 1'b1;
                    quo_reg  <= {an, 16'h0000};
                    rem_reg  <= '0;
                    div_reg  <= 32'(ar);
                    dcnt_reg <= '0;
                end
            end
            grcc_pkg::ST_DIV_DIST:
            begin
                dcnt_reg <= dcnt_reg + DCW'(1);
                quo_reg  <= quo_nx;
                rem_reg  <= rem_nx;
                if (div_last)
                begin
                    dist_reg <= dist_sat;
                    div_reg  <= dist_sat;
                    quo_reg  <= NW'({sh_reg, 16'h0000});
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                end
            end
            grcc_pkg::ST_DIV_HT:
            begin
                dcnt_reg <= dcnt_reg + DCW'(1);
                quo_reg  <= quo_nx;
                rem_reg  <= rem_nx;
                if (div_last)
                begin
                    height_reg <= ht_sat;
                end
            end
            grcc_pkg::ST_TEX_WB:
            begin
                beg_reg <= (h2 >= 15'(half)) ? 13'd0 : 13'(15'(half) - h2);
                end_reg <= (end_sum > 16'(sh_reg)) ? sh_reg : end_sum[12:0];
                if (tw_reg == 11'd0)
                begin
                    tex_reg <= '0;
                end
                else if (mirror)
                begin
                    tex_reg <= 10'(tw_reg - tex_raw - 11'd1);
                end
                else
                begin
                    tex_reg <= tex_raw[9:0];
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (state_reg == grcc_pkg::ST_DONE && out_free)
        begin
            out_valid <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == grcc_pkg::ST_DONE && out_free)
        begin
            hit_found      <= hit_reg;
            hit_side       <= hit_reg & side_reg;
            hit_cell_x     <= hit_reg ? gx_reg[5:0] : 6'd0;
            hit_cell_y     <= hit_reg ? gy_reg[5:0] : 6'd0;
            wall_distance  <= hit_reg ? dist_reg : 32'd0;
            slice_height   <= hit_reg ? height_reg : 16'd0;
            slice_begin    <= hit_reg ? beg_reg : 13'd0;
            slice_end      <= hit_reg ? end_reg : 13'd0;
            texture_column <= hit_reg ? tex_reg : 10'd0;
        end
    end

endmodule

[rtl/grcc_checker.sv]
// grcc_checker: port-level assertions for grid_ray_caster_column_core
// depends on grcc_pkg; attached to the core by the bind at the end
module grcc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               cmd,
    input logic               out_valid,
    input logic               out_stall,
    input logic               hit_found,
    input logic               hit_side,
    input logic [5:0]         hit_cell_x,
    input logic [5:0]         hit_cell_y,
    input logic [31:0]        wall_distance,
    input logic [15:0]        slice_height,
    input logic [12:0]        slice_begin,
    input logic [12:0]        slice_end,
    input logic [9:0]         texture_column
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(wall_distance) && $stable(hit_found))
        else $error("stalled result changed");

    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == grcc_pkg::CMD_CAST |=> in_stall)
        else $error("cast transfer did not make the core busy");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit_found |-> !hit_side && hit_cell_x == 6'd0 && hit_cell_y == 6'd0 &&
        wall_distance == 32'd0 && slice_height == 16'd0 && slice_begin == 13'd0 &&
        slice_end == 13'd0 && texture_column == 10'd0)
        else $error("miss result carries nonzero fields");

    a_slice_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit_found |-> slice_begin <= slice_end)
        else $error("slice begin past slice end");

    a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit_found && wall_distance == 32'd0 |-> slice_height == 16'hFFFF)
        else $error("zero distance without saturated height");

endmodule

bind grid_ray_caster_column_core grcc_checker u_grcc_checker (.*);

[verif/tb_grid_ray_caster_column_core.sv]
// tb_grid_ray_caster_column_core: self-checking bench for the grid ray caster column core
// walks directed map writes and casts, then random ones; checks each result against a
// bit-true predictor, three directed casts as misses; depends on grcc_pkg and the core
`timescale 1ns / 1ps

module tb_grid_ray_caster_column_core;

    typedef struct packed {
        logic               cmd;
        logic [5:0]         row;
        logic [5:0]         col;
        logic               wall;
        logic [21:0]        px;
        logic [21:0]        py;
        logic signed [18:0] rx;
        logic signed [18:0] ry;
        logic [31:0]        dx;
        logic [31:0]        dy;
    } ray_item_t;

    typedef struct packed {
        logic        hit;
        logic        side;
        logic [5:0]  cx;
        logic [5:0]  cy;
        logic [31:0] wdist;
        logic [15:0] height;
        logic [12:0] sbeg;
        logic [12:0] send;
        logic [9:0]  tcol;
    } column_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 500;
    localparam int PHASE_ITEMS    = 320;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               cmd = 1'b0;
    logic [5:0]         cell_row = '0;
    logic [5:0]         cell_col = '0;
    logic               cell_is_wall = 1'b0;
    logic [21:0]        pos_x = '0;
    logic [21:0]        pos_y = '0;
    logic signed [18:0] ray_x = '0;
    logic signed [18:0] ray_y = '0;
    logic [31:0]        delta_x = '0;
    logic [31:0]        delta_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               hit_found;
    logic               hit_side;
    logic [5:0]         hit_cell_x;
    logic [5:0]         hit_cell_y;
    logic [31:0]        wall_distance;
    logic [15:0]        slice_height;
    logic [12:0]        slice_begin;
    logic [12:0]        slice_end;
    logic [9:0]         texture_column;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [12:0]        cfg_data = '0;

    bit          wall_bits [64][64];
    logic [12:0] scr_h = grcc_pkg::SCREEN_HEIGHT_RESET;
    logic [10:0] tex_w = grcc_pkg::TEXTURE_WIDTH_RESET;
    column_t     column_q [$];
    int          n_errors = 0;
    int          n_casts = 0;
    int          n_hits = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;
    bit          long_hold_req = 1'b0;
    int          stall_left = 0;

    grid_ray_caster_column_core DUT (.*);

    always #1 clk = ~clk;

    function automatic column_t cast_column(ray_item_t s);
        longint gx, gy, sx, sy, nx, ny, num, ar, q, hs, t;
        logic [63:0] prod;
        logic [15:0] fr;
        longint ht, half, beg, fin;
        bit side, hit;
        column_t r;
        r = '0;
        side = 1'b0;
        hit = 1'b0;
        gx = s.px >> 16;
        gy = s.py >> 16;
        sx = s.rx < 0 ? -1 : 1;
        sy = s.ry < 0 ? -1 : 1;
        nx = ((s.rx < 0 ? longint'(s.px[15:0]) : 65536 - longint'(s.px[15:0]))
              * longint'(s.dx)) >> 16;
        ny = ((s.ry < 0 ? longint'(s.py[15:0]) : 65536 - longint'(s.py[15:0]))
              * longint'(s.dy)) >> 16;
        for (int n = 0; n < 128; n++)
        begin
            if (nx < ny)
            begin
                nx += s.dx;
                gx += sx;
                side = 1'b0;
            end
            else
            begin
                ny += s.dy;
                gy += sy;
                side = 1'b1;
            end
            if (gx < 0 || gx >= 64 || gy < 0 || gy >= 64)
                break;
            if (wall_bits[gx][gy])
            begin
                hit = 1'b1;
                break;
            end
        end
        if (!hit)
            return r;
        if (side == 1'b0)
        begin
            num = gx * 65536 + (s.rx < 0 ? 65536 : 0) - longint'(s.px);
            ar = s.rx < 0 ? -longint'(s.rx) : longint'(s.rx);
        end
        else
        begin
            num = gy * 65536 + (s.ry < 0 ? 65536 : 0) - longint'(s.py);
            ar = s.ry < 0 ? -longint'(s.ry) : longint'(s.ry);
        end
        if (num < 0)
            num = -num;
        if (ar == 0)
            r.wdist = 32'hFFFF_FFFF;
        else
        begin
            q = (num << 16) / ar;
            r.wdist = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
        end
        if (r.wdist == 0)
            ht = 65535;
        else
        begin
            hs = (longint'(scr_h) << 16) / longint'(r.wdist);
            ht = hs > 65535 ? 65535 : hs;
        end
        half = scr_h / 2;
        beg = (ht / 2 >= half) ? 0 : half - ht / 2;
        fin = half + ht / 2;
        if (fin > scr_h)
            fin = scr_h;
        if (side == 1'b0)
            prod = 64'(r.wdist) * 64'(longint'(s.ry));
        else
            prod = 64'(r.wdist) * 64'(longint'(s.rx));
        fr = 16'((side == 1'b0 ? 64'(s.py) : 64'(s.px)) + (prod >> 16));
        t = (longint'(fr) * longint'(tex_w)) >> 16;
        if (tex_w == 0)
            t = 0;
        else if ((side == 1'b0 && s.rx > 0) || (side == 1'b1 && s.ry < 0))
            t = longint'(tex_w) - t - 1;
        r.hit = 1'b1;
        r.side = side;
        r.cx = gx[5:0];
        r.cy = gy[5:0];
        r.height = ht[15:0];
        r.sbeg = beg[12:0];
        r.send = fin[12:0];
        r.tcol = t[9:0];
        return r;
    endfunction

    task automatic send_item(ray_item_t s, bit typed, column_t typed_col);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= s.cmd;
        cell_row <= s.row;
        cell_col <= s.col;
        cell_is_wall <= s.wall;
        pos_x <= s.px;
        pos_y <= s.py;
        ray_x <= s.rx;
        ray_y <= s.ry;
        delta_x <= s.dx;
        delta_y <= s.dy;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        if (s.cmd == grcc_pkg::CMD_MAP_WRITE)
            wall_bits[s.row][s.col] = s.wall;
        else
        begin
            column_q.push_back(typed ? typed_col : cast_column(s));
            n_casts++;
        end
    endtask

    task automatic write_reg(logic idx, logic [12:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == grcc_pkg::REG_SCREEN_HEIGHT)
            scr_h = val;
        else
            tex_w = val[10:0];
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (column_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic ray_item_t random_item();
        ray_item_t s;
        longint a;
        s.cmd = $urandom_range(0, 99) < 35 ? grcc_pkg::CMD_MAP_WRITE : grcc_pkg::CMD_CAST;
        s.row = $urandom_range(0, 63);
        s.col = $urandom_range(0, 63);
        s.wall = $urandom_range(0, 1);
        s.px = $urandom_range(0, 22'h3FFFFF);
        s.py = $urandom_range(0, 22'h3FFFFF);
        s.rx = $urandom_range(0, 19'h7FFFF);
        s.ry = $urandom_range(0, 19'h7FFFF);
        if ($urandom_range(0, 9) == 0)
        begin
            s.dx = $urandom();
            s.dy = $urandom();
        end
        else
        begin
            a = s.rx < 0 ? -longint'(s.rx) : longint'(s.rx);
            s.dx = a == 0 ? 32'hFFFF_FFFF : 32'((64'd1 << 32) / a);
            a = s.ry < 0 ? -longint'(s.ry) : longint'(s.ry);
            s.dy = a == 0 ? 32'hFFFF_FFFF : 32'((64'd1 << 32) / a);
        end
        return s;
    endfunction

    // directed rows: cmd row col wall px py rx ry dx dy
    ray_item_t dir_tab [16] = '{
        '{grcc_pkg::CMD_CAST, 6'd0, 6'd0, 1'b0, 22'd0, 22'd0, 19'sd65536, 19'sd0,
          32'h10000, 32'hFFFFFFFF},
        '{grcc_pkg::CMD_CAST, 6'd0, 6'd0, 1'b0, 22'h3FFFFF, 22'h3FFFFF,
          -19'sd262144, -19'sd262144, 32'h0, 32'h0},
        '{grcc_pkg::CMD_MAP_WRITE, 6'd10, 6'd5, 1'b1, 22'd0, 22'd0, 19'sd0, 19'sd0,
          32'h0, 32'h0},
        '{grcc_pkg::CMD_CAST, 6'd0, 6'd0, 1'b0, 22'h58000, 22'h58000, 19'sd65536, 19'sd0,
          32'h10000, 32'hFFFFFFFF},
        '{grcc_pkg::CMD_CAST, 6'd0, 6'd0, 1'b0, 22'h58000, 22'h58000, 19'sd0, 19'sd0,
          32'h10000, 32'hFFFFFFFF},
        '{grcc_pkg::CMD_CAST, 6'd0, 6'd0, 1'b0, 22'hB0000, 22'h58000, -19'sd65536, 19'sd0,
          32'h10000, 32'hFFFFFFFF},
        '{grcc_pkg::CMD_CAST, 6'd0, 6'd0, 1'b0, 22'h5C000, 22'h54000, 19'sd40000,
          -19'sd3000, 32'h1A36E, 32'h15D867},
        '{grcc_pkg::CMD_MAP_WRITE, 6'd63, 6'd63, 1'b1, 22'd0, 22'd0, 19'sd0, 19'sd0,
          32'h0, 32'h0},
        '{grcc_pkg::CMD_CAST, 6'd0, 6'd0, 1'b0, 22'h3E8000, 22'h3E8000, 19'sd262143,
          19'sd262143, 32'h4000, 32'h4000},
        '{grcc_pkg::CMD_MAP_WRITE, 6'd10, 6'd5, 1'b0, 22'd0, 22'd0, 19'sd0, 19'sd0,
          32'h0, 32'h0},
        '{grcc_pkg::CMD_CAST, 6'd0, 6'd0, 1'b0, 22'h58000, 22'h58000, 19'sd65536, 19'sd0,
          32'h10000, 32'hFFFFFFFF},
        '{grcc_pkg::CMD_MAP_WRITE, 6'd0, 6'd0, 1'b1, 22'd0, 22'd0, 19'sd0, 19'sd0,
          32'h0, 32'h0},
        '{grcc_pkg::CMD_MAP_WRITE, 6'd63, 6'd0, 1'b1, 22'd0, 22'd0, 19'sd0, 19'sd0,
          32'h0, 32'h0},
        '{grcc_pkg::CMD_MAP_WRITE, 6'd0, 6'd63, 1'b1, 22'd0, 22'd0, 19'sd0, 19'sd0,
          32'h0, 32'h0},
        '{grcc_pkg::CMD_CAST, 6'd0, 6'd0, 1'b0, 22'h38000, 22'h38000, -19'sd262144,
          -19'sd262144, 32'h4000, 32'h4000},
        '{grcc_pkg::CMD_CAST, 6'd0, 6'd0, 1'b0, 22'h3F8000, 22'h8000, 19'sd100,
          -19'sd70000, 32'hFFFFFFFF, 32'hEA0A}
    };
    bit dir_typed [16] = '{1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0};

    // receiver: random stall bursts plus one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = 700;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        column_t e;
        if (out_valid && !out_stall)
        begin
            if (column_q.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                n_errors++;
            end
            else
            begin
                e = column_q.pop_front();
                if (hit_found)
                    n_hits++;
                if (hit_found !== e.hit)
                begin
                    $error("hit_found exp %0d got %0d", e.hit, hit_found);
                    n_errors++;
                end
                if (hit_side !== e.side)
                begin
                    $error("hit_side exp %0d got %0d", e.side, hit_side);
                    n_errors++;
                end
                if (hit_cell_x !== e.cx)
                begin
                    $error("hit_cell_x exp %0d got %0d", e.cx, hit_cell_x);
                    n_errors++;
                end
                if (hit_cell_y !== e.cy)
                begin
                    $error("hit_cell_y exp %0d got %0d", e.cy, hit_cell_y);
                    n_errors++;
                end
                if (wall_distance !== e.wdist)
                begin
                    $error("wall_distance exp %h got %h", e.wdist, wall_distance);
                    n_errors++;
                end
                if (slice_height !== e.height)
                begin
                    $error("slice_height exp %0d got %0d", e.height, slice_height);
                    n_errors++;
                end
                if (slice_begin !== e.sbeg)
                begin
                    $error("slice_begin exp %0d got %0d", e.sbeg, slice_begin);
                    n_errors++;
                end
                if (slice_end !== e.send)
                begin
                    $error("slice_end exp %0d got %0d", e.send, slice_end);
                    n_errors++;
                end
                if (texture_column !== e.tcol)
                begin
                    $error("texture_column exp %0d got %0d", e.tcol, texture_column);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [12:0] sh_set [4];
        logic [12:0] tw_set [4];
        sh_set = '{13'd480, 13'd4096, 13'd1, 13'd0};
        tw_set = '{13'd64, 13'd1024, 13'd0, 13'd2047};
        sh_set[3] = $urandom_range(2, 4095);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < 16; i++)
            send_item(dir_tab[i], dir_typed[i], '0);
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            write_reg(grcc_pkg::REG_SCREEN_HEIGHT, sh_set[ph]);
            write_reg(grcc_pkg::REG_TEXTURE_WIDTH, tw_set[ph]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 1 && i == 100)
                    long_hold_req = 1'b1;
                if (ph == 3 && i == PHASE_ITEMS - 150)
                    quiet = 1'b1;
                send_item(random_item(), 1'b0, '0);
            end
        end
        drain();
        $display("covered %0d casts (%0d wall hits) across 4 register settings",
                 n_casts, n_hits);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
